@@ sv/tqs_pkg.sv @@
// ----------------------------------------------------------------------------
// tqs_pkg
// Types and constants shared by the thermometer query sequencer modules.
// ----------------------------------------------------------------------------
package tqs_pkg;

  typedef enum logic [1:0] {
    CMD_HOST_WRITE = 2'd0,
    CMD_BUS_STEP   = 2'd1,
    CMD_EP_READY   = 2'd2,
    CMD_BUS_RESET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } bus_op_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_RESET1   = 5'd1,
    ST_SKIP1    = 5'd2,
    ST_CONVERT  = 5'd3,
    ST_POLL     = 5'd4,
    ST_RESET2   = 5'd5,
    ST_SKIP2    = 5'd6,
    ST_READ_CMD = 5'd7,
    ST_RD0      = 5'd8,
    ST_RD1      = 5'd9,
    ST_RD2      = 5'd10,
    ST_RD3      = 5'd11,
    ST_RD4      = 5'd12,
    ST_RD5      = 5'd13,
    ST_RD6      = 5'd14,
    ST_RD7      = 5'd15,
    ST_RD8      = 5'd16,
    ST_FINISH   = 5'd17
  } step_e;

  // one-wire commands
  localparam logic [7:0] OW_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] OW_CONVERT   = 8'h44;
  localparam logic [7:0] OW_READ_PAD  = 8'hBE;
  localparam logic [7:0] OW_DONE      = 8'hFF;

  // host query codes
  localparam logic [7:0] Q_TEMP_B1    = 8'h80;
  localparam logic [7:0] Q_TEMP_B2    = 8'h33;
  localparam logic [7:0] Q_VER_B1     = 8'h82;
  localparam logic [7:0] Q_VER_B2     = 8'h77;
  localparam logic [7:0] Q_ID_B1      = 8'h86;
  localparam logic [7:0] Q_ID_B2      = 8'hFF;

  localparam logic [3:0] LEN_LED      = 4'd1;
  localparam logic [3:0] LEN_QUERY    = 4'd8;

  localparam logic [63:0] TEMP_HEADER = 64'h0000_0000_0000_0280;
  localparam logic [23:0] VER_REPLY   = 24'h00_01_82;
  localparam logic [63:0] ID_TEXT     = 64'h3146_7265_504D_4554;
  localparam logic [15:0] ID_TAIL     = 16'h322E;
  localparam logic [7:0]  ID_FIRST    = 8'h54;

  localparam logic [7:0]  ERR_HIGH    = 8'hFF;
  localparam logic [7:0]  ERR_LOW_1   = 8'hFF;
  localparam logic [7:0]  ERR_LOW_2   = 8'hFE;
  localparam logic [7:0]  LED_RESET   = 8'hFF;
  localparam int unsigned LED_FLAG_BIT = 1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  write_length;
    logic [63:0] write_bytes;
    logic        presence_seen;
    logic [7:0]  bus_read_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  bus_op;
    logic [7:0]  bus_write_value;
    logic [3:0]  accepted_length;
    logic        led_on;
    logic        report_valid;
    logic [63:0] report_bytes;
  } out_item_t;

endpackage

@@ sv/tqs_in_if.sv @@
// ----------------------------------------------------------------------------
// tqs_in_if
// Input word channel: command, host payload and one-wire step data.
// ----------------------------------------------------------------------------
interface tqs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  write_length;
  logic [63:0] write_bytes;
  logic        presence_seen;
  logic [7:0]  bus_read_value;

  modport source (
    output valid, command, write_length, write_bytes, presence_seen, bus_read_value,
    input  ready
  );

  modport sink (
    input  valid, command, write_length, write_bytes, presence_seen, bus_read_value,
    output ready
  );
endinterface

@@ sv/tqs_out_if.sv @@
// ----------------------------------------------------------------------------
// tqs_out_if
// Result word channel: bus operation, host acceptance, LED and report.
// ----------------------------------------------------------------------------
interface tqs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_op;
  logic [7:0]  bus_write_value;
  logic [3:0]  accepted_length;
  logic        led_on;
  logic        report_valid;
  logic [63:0] report_bytes;

  modport source (
    output valid, bus_op, bus_write_value, accepted_length, led_on, report_valid,
    output report_bytes,
    input  ready
  );

  modport sink (
    input  valid, bus_op, bus_write_value, accepted_length, led_on, report_valid,
    input  report_bytes,
    output ready
  );
endinterface

@@ sv/thermometer_query_sequencer.sv @@
// ----------------------------------------------------------------------------
// thermometer_query_sequencer
// Path: input register, step logic, result register; an accepted word is
// held in the first and its result word in the last. One word per cycle
// unless the result side stalls. The input side stays ready while a result
// waits, as long as the input register is free or moves on in the same cycle.
// Reset: asynchronous active low; sequencer idle, no report pending, LED off.
// ----------------------------------------------------------------------------
module thermometer_query_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tqs_in_if.sink    in_i,
  tqs_out_if.source out_o
);
  import tqs_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      advance;
  logic      in_fire;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.command        <= in_i.command;
      in_item_q.write_length   <= in_i.write_length;
      in_item_q.write_bytes    <= in_i.write_bytes;
      in_item_q.presence_seen  <= in_i.presence_seen;
      in_item_q.bus_read_value <= in_i.bus_read_value;
    end
  end

  tqs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.bus_op          = out_item_q.bus_op;
  assign out_o.bus_write_value = out_item_q.bus_write_value;
  assign out_o.accepted_length = out_item_q.accepted_length;
  assign out_o.led_on          = out_item_q.led_on;
  assign out_o.report_valid    = out_item_q.report_valid;
  assign out_o.report_bytes    = out_item_q.report_bytes;

endmodule

@@ sv/tqs_core.sv @@
// ----------------------------------------------------------------------------
// tqs_core
// Sequencer state and the single-pass step logic for one word.
// ----------------------------------------------------------------------------
module tqs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tqs_pkg::in_item_t item_i,
  output tqs_pkg::out_item_t res_o
);
  import tqs_pkg::*;

  step_e       step_q, step_d;
  logic [63:0] report_q, report_d;
  logic        pending_q, pending_d;
  logic [7:0]  last_led_q, last_led_d;
  logic        led_q, led_d;
  logic [7:0]  rbyte_q [2];
  logic        store0, store1;

  logic [7:0]  wb0, wb1, wb2, wb3;
  logic        is_query;

  assign wb0 = item_i.write_bytes[7:0];
  assign wb1 = item_i.write_bytes[15:8];
  assign wb2 = item_i.write_bytes[23:16];
  assign wb3 = item_i.write_bytes[31:24];
  assign is_query = (item_i.command == CMD_HOST_WRITE) && (item_i.write_length == LEN_QUERY)
                    && (wb0 == 8'd1) && (wb3 == 8'd1) && (item_i.write_bytes[63:32] == '0);

  // next step
  always_comb begin
    step_d = step_q;
    unique case (cmd_e'(item_i.command))
      CMD_HOST_WRITE: begin
        if (is_query && wb1 == Q_TEMP_B1 && wb2 == Q_TEMP_B2) begin
          step_d = ST_RESET1;
        end
      end
      CMD_BUS_STEP: begin
        unique case (step_q)
          ST_IDLE:     step_d = ST_IDLE;
          ST_RESET1:   step_d = item_i.presence_seen ? ST_SKIP1 : ST_IDLE;
          ST_SKIP1:    step_d = ST_CONVERT;
          ST_CONVERT:  step_d = ST_POLL;
          ST_POLL:     step_d = (item_i.bus_read_value == OW_DONE) ? ST_RESET2 : ST_POLL;
          ST_RESET2:   step_d = item_i.presence_seen ? ST_SKIP2 : ST_IDLE;
          ST_SKIP2:    step_d = ST_READ_CMD;
          ST_READ_CMD: step_d = ST_RD0;
          ST_RD0:      step_d = ST_RD1;
          ST_RD1:      step_d = ST_RD2;
          ST_RD2:      step_d = ST_RD3;
          ST_RD3:      step_d = ST_RD4;
          ST_RD4:      step_d = ST_RD5;
          ST_RD5:      step_d = ST_RD6;
          ST_RD6:      step_d = ST_RD7;
          ST_RD7:      step_d = ST_RD8;
          ST_RD8:      step_d = ST_FINISH;
          ST_FINISH:   step_d = ST_IDLE;
          default:     step_d = ST_IDLE;
        endcase
      end
      CMD_EP_READY:  step_d = step_q;
      CMD_BUS_RESET: step_d = ST_IDLE;
      default:       step_d = step_q;
    endcase
  end

  // outputs and data state
  always_comb begin
    report_d   = report_q;
    pending_d  = pending_q;
    last_led_d = last_led_q;
    led_d      = led_q;
    store0     = 1'b0;
    store1     = 1'b0;
    res_o      = '0;
    unique case (cmd_e'(item_i.command))
      CMD_HOST_WRITE: begin
        if (item_i.write_length == LEN_LED) begin
          led_d = 1'b1;
          if (wb0 != last_led_q) begin
            last_led_d = wb0;
            led_d      = wb0[LED_FLAG_BIT];
          end
          res_o.accepted_length = LEN_LED;
        end else if (item_i.write_length == LEN_QUERY) begin
          res_o.accepted_length = LEN_QUERY;
          if (is_query) begin
            priority if (wb1 == Q_TEMP_B1 && wb2 == Q_TEMP_B2) begin
              report_d = TEMP_HEADER;
            end else if (wb1 == Q_VER_B1 && wb2 == Q_VER_B2) begin
              report_d[23:0] = VER_REPLY;
              pending_d      = 1'b1;
            end else if (wb1 == Q_ID_B1 && wb2 == Q_ID_B2) begin
              report_d  = ID_TEXT;
              pending_d = 1'b1;
            end
          end
        end
      end
      CMD_BUS_STEP: begin
        unique case (step_q)
          ST_RESET1, ST_RESET2: begin
            res_o.bus_op = OP_RESET;
            if (!item_i.presence_seen) begin
              report_d[23:16] = ERR_HIGH;
              report_d[31:24] = (step_q == ST_RESET1) ? ERR_LOW_1 : ERR_LOW_2;
              pending_d       = 1'b1;
            end
          end
          ST_SKIP1, ST_SKIP2: begin
            res_o.bus_op          = OP_WRITE;
            res_o.bus_write_value = OW_SKIP_ROM;
          end
          ST_CONVERT: begin
            res_o.bus_op          = OP_WRITE;
            res_o.bus_write_value = OW_CONVERT;
          end
          ST_READ_CMD: begin
            res_o.bus_op          = OP_WRITE;
            res_o.bus_write_value = OW_READ_PAD;
          end
          ST_POLL, ST_RD2, ST_RD3, ST_RD4, ST_RD5, ST_RD6, ST_RD7, ST_RD8: begin
            res_o.bus_op = OP_READ;
          end
          ST_RD0: begin
            res_o.bus_op = OP_READ;
            store0       = 1'b1;
          end
          ST_RD1: begin
            res_o.bus_op = OP_READ;
            store1       = 1'b1;
          end
          ST_FINISH: begin
            report_d[23:16] = {rbyte_q[1][3:0], rbyte_q[0][7:4]};
            report_d[31:24] = {rbyte_q[0][3:0], 4'h0};
            pending_d       = 1'b1;
          end
          default: res_o.bus_op = OP_NONE;
        endcase
      end
      CMD_EP_READY: begin
        if (pending_q) begin
          res_o.report_valid = 1'b1;
          res_o.report_bytes = report_q;
          if (report_q[7:0] == ID_FIRST) begin
            report_d[15:0] = ID_TAIL;
          end else begin
            pending_d = 1'b0;
          end
        end
      end
      CMD_BUS_RESET: pending_d = 1'b0;
      default:       pending_d = pending_q;
    endcase
    res_o.led_on = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      report_q   <= '0;
      pending_q  <= 1'b0;
      last_led_q <= LED_RESET;
      led_q      <= 1'b0;
    end else if (fire_i) begin
      step_q     <= step_d;
      report_q   <= report_d;
      pending_q  <= pending_d;
      last_led_q <= last_led_d;
      led_q      <= led_d;
    end
  end

  // scratchpad bytes kept for the report
  always_ff @(posedge clk_i) begin
    if (fire_i && store0) begin
      rbyte_q[0] <= item_i.bus_read_value;
    end
    if (fire_i && store1) begin
      rbyte_q[1] <= item_i.bus_read_value;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thermometer query sequencer. Host writes, bus
// steps, endpoint-ready events and bus resets go in as words on the input
// channel; a scoreboard class tracks the sequencer, report and LED state and
// checks every result word in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import tqs_pkg::*;

  localparam int          ITEM_TARGET    = 450;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [7:0]  QUERY_MARK     = 8'h01;

  class temp_query_scoreboard;
    step_e       step_q;
    logic [63:0] report_q;
    bit          pending_q;
    logic [7:0]  raw_q [2];
    logic [7:0]  led_byte_q;
    bit          led_q;
    out_item_t   expected_q [$];
    int          mismatches;

    function new();
      step_q     = ST_IDLE;
      report_q   = '0;
      pending_q  = 1'b0;
      raw_q[0]   = '0;
      raw_q[1]   = '0;
      led_byte_q = LED_RESET;
      led_q      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_report_byte(int k, logic [7:0] b);
      report_q[8*k +: 8] = b;
    endfunction

    function void note_input(in_item_t w);
      out_item_t  r;
      logic [7:0] q1;
      logic [7:0] q2;
      r  = '0;
      q1 = w.write_bytes[15:8];
      q2 = w.write_bytes[23:16];
      case (cmd_e'(w.command))
        CMD_HOST_WRITE: begin
          if (w.write_length == LEN_LED) begin
            led_q = 1'b1;
            if (w.write_bytes[7:0] != led_byte_q) begin
              led_byte_q = w.write_bytes[7:0];
              led_q      = w.write_bytes[LED_FLAG_BIT];
            end
            r.accepted_length = LEN_LED;
          end else if (w.write_length == LEN_QUERY) begin
            r.accepted_length = LEN_QUERY;
            if (w.write_bytes[7:0] == QUERY_MARK && w.write_bytes[63:32] == '0 &&
                w.write_bytes[31:24] == QUERY_MARK) begin
              if (q1 == Q_TEMP_B1 && q2 == Q_TEMP_B2) begin
                report_q = TEMP_HEADER;
                step_q   = ST_RESET1;
              end else if (q1 == Q_VER_B1 && q2 == Q_VER_B2) begin
                pending_q      = 1'b1;
                report_q[23:0] = VER_REPLY;
              end else if (q1 == Q_ID_B1 && q2 == Q_ID_B2) begin
                pending_q = 1'b1;
                report_q  = ID_TEXT;
              end
            end
          end
        end
        CMD_BUS_STEP: begin
          case (step_q)
            ST_RESET1, ST_RESET2: begin
              r.bus_op = OP_RESET;
              if (w.presence_seen) begin
                step_q = step_e'(step_q + 5'd1);
              end else begin
                set_report_byte(2, ERR_HIGH);
                set_report_byte(3, (step_q == ST_RESET1) ? ERR_LOW_1 : ERR_LOW_2);
                pending_q = 1'b1;
                step_q    = ST_IDLE;
              end
            end
            ST_SKIP1, ST_SKIP2: begin
              r.bus_op          = OP_WRITE;
              r.bus_write_value = OW_SKIP_ROM;
              step_q            = step_e'(step_q + 5'd1);
            end
            ST_CONVERT: begin
              r.bus_op          = OP_WRITE;
              r.bus_write_value = OW_CONVERT;
              step_q            = ST_POLL;
            end
            ST_READ_CMD: begin
              r.bus_op          = OP_WRITE;
              r.bus_write_value = OW_READ_PAD;
              step_q            = ST_RD0;
            end
            ST_POLL: begin
              r.bus_op = OP_READ;
              if (w.bus_read_value == OW_DONE) step_q = ST_RESET2;
            end
            ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5, ST_RD6, ST_RD7, ST_RD8: begin
              r.bus_op = OP_READ;
              if (step_q == ST_RD0) raw_q[0] = w.bus_read_value;
              if (step_q == ST_RD1) raw_q[1] = w.bus_read_value;
              step_q = step_e'(step_q + 5'd1);
            end
            ST_FINISH: begin
              set_report_byte(2, {raw_q[1][3:0], raw_q[0][7:4]});
              set_report_byte(3, {raw_q[0][3:0], 4'h0});
              pending_q = 1'b1;
              step_q    = ST_IDLE;
            end
            default: step_q = ST_IDLE;
          endcase
        end
        CMD_EP_READY: begin
          if (pending_q) begin
            r.report_valid = 1'b1;
            r.report_bytes = report_q;
            if (report_q[7:0] == ID_FIRST) report_q[15:0] = ID_TAIL;
            else pending_q = 1'b0;
          end
        end
        default: begin
          step_q    = ST_IDLE;
          pending_q = 1'b0;
        end
      endcase
      r.led_on = led_q;
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result word with nothing expected: %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.bus_op !== want.bus_op || got.bus_write_value !== want.bus_write_value ||
          got.accepted_length !== want.accepted_length || got.led_on !== want.led_on ||
          got.report_valid !== want.report_valid ||
          got.report_bytes !== want.report_bytes) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: mismatch, expected op=%0d wr=%h len=%0d led=%b rv=%b rep=%h",
                   $time, want.bus_op, want.bus_write_value, want.accepted_length,
                   want.led_on, want.report_valid, want.report_bytes);
          $display("%0t:           actual   op=%0d wr=%h len=%0d led=%b rv=%b rep=%h",
                   $time, got.bus_op, got.bus_write_value, got.accepted_length,
                   got.led_on, got.report_valid, got.report_bytes);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tqs_in_if  in_if ();
  tqs_out_if out_if ();

  thermometer_query_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  temp_query_scoreboard sb = new();
  int items_sent;
  bit no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_item_t any_word();
    in_item_t w;
    w.command        = 2'($urandom_range(0, 3));
    w.write_length   = 4'($urandom_range(0, 15));
    w.write_bytes    = {$urandom, $urandom};
    w.presence_seen  = 1'($urandom_range(0, 1));
    w.bus_read_value = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic in_item_t plain(cmd_e cmd);
    in_item_t w;
    w         = any_word();
    w.command = cmd;
    return w;
  endfunction

  function automatic in_item_t host_write(logic [3:0] len, logic [63:0] data);
    in_item_t w;
    w              = plain(CMD_HOST_WRITE);
    w.write_length = len;
    w.write_bytes  = data;
    return w;
  endfunction

  function automatic logic [63:0] query_payload(logic [7:0] b1, logic [7:0] b2);
    return {32'h0, QUERY_MARK, b2, b1, QUERY_MARK};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // called and returning at a falling edge; valid stays high after the word
  task automatic send_word(in_item_t w);
    int gap;
    int r;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= w.command;
    in_if.write_length   <= w.write_length;
    in_if.write_bytes    <= w.write_bytes;
    in_if.presence_seen  <= w.presence_seen;
    in_if.bus_read_value <= w.bus_read_value;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_input(w);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // temperature query, then bus steps while the sequencer is busy
  task automatic run_readout(bit pres1, bit pres2, int polls, logic [7:0] lsb,
                             logic [7:0] msb, int step_budget);
    in_item_t w;
    int       n;
    int       polls_left;
    send_word(host_write(LEN_QUERY, query_payload(Q_TEMP_B1, Q_TEMP_B2)));
    polls_left = polls;
    n = 0;
    while (sb.step_q != ST_IDLE && n < step_budget) begin
      w = plain(CMD_BUS_STEP);
      case (sb.step_q)
        ST_RESET1: w.presence_seen = pres1;
        ST_RESET2: w.presence_seen = pres2;
        ST_POLL: begin
          if (polls_left > 0) begin
            w.bus_read_value = 8'($urandom_range(0, 254));
            polls_left--;
          end else begin
            w.bus_read_value = OW_DONE;
          end
        end
        ST_RD0:  w.bus_read_value = lsb;
        ST_RD1:  w.bus_read_value = msb;
        default: ;
      endcase
      send_word(w);
      n++;
    end
  endtask

  // result side stalls
  initial begin
    int stretch;
    int n;
    bit calm;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stretch = $urandom_range(20, 60);
      calm    = ($urandom_range(0, 3) == 0);
      while (stretch > 0) begin
        @(negedge clk_i);
        stretch--;
        if (calm || $urandom_range(0, 99) < 60) begin
          out_if.ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 92) begin
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b0;
          n = $urandom_range(8, 40);
          repeat (n) @(negedge clk_i);
          stretch -= n;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result({out_if.bus_op, out_if.bus_write_value, out_if.accepted_length,
                       out_if.led_on, out_if.report_valid, out_if.report_bytes});
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          pick;
    int          next_drain;
    logic [63:0] data;
    items_sent           = 0;
    no_gaps              = 1'b0;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_HOST_WRITE;
    in_if.write_length   = '0;
    in_if.write_bytes    = '0;
    in_if.presence_seen  = 1'b0;
    in_if.bus_read_value = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words
    send_word(plain(CMD_EP_READY));
    send_word(plain(CMD_BUS_STEP));
    send_word(host_write(LEN_LED, {56'h0, LED_RESET}));
    send_word(host_write(LEN_LED, {56'h0, 8'h02}));
    send_word(host_write(LEN_LED, {56'hFF_FFFF_FFFF_FFFF, 8'h02}));
    send_word(host_write(LEN_LED, 64'h0));
    send_word(host_write(4'd0, {$urandom, $urandom}));
    send_word(host_write(4'hF, '1));
    send_word(host_write(LEN_QUERY, '1));
    send_word(host_write(LEN_QUERY, query_payload(Q_VER_B1, Q_VER_B2)));
    send_word(plain(CMD_EP_READY));
    send_word(host_write(LEN_QUERY, query_payload(Q_ID_B1, Q_ID_B2)));
    repeat (3) send_word(plain(CMD_EP_READY));
    run_readout(1'b0, 1'b1, 0, 8'h00, 8'h00, 100);
    send_word(plain(CMD_EP_READY));
    run_readout(1'b1, 1'b0, 0, 8'h00, 8'h00, 100);
    send_word(plain(CMD_EP_READY));
    wait_drained();

    next_drain = items_sent + 100;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + $urandom_range(80, 130);
      end
      if ($urandom_range(0, 15) == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_readout($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3),
                    pick_byte(), pick_byte(), 100);
        if ($urandom_range(0, 3) != 0) send_word(plain(CMD_EP_READY));
      end else if (pick < 48) begin
        send_word(host_write(LEN_QUERY, query_payload(Q_VER_B1, Q_VER_B2)));
        send_word(plain(CMD_EP_READY));
      end else if (pick < 54) begin
        send_word(host_write(LEN_QUERY, query_payload(Q_ID_B1, Q_ID_B2)));
        repeat ($urandom_range(1, 3)) send_word(plain(CMD_EP_READY));
      end else if (pick < 64) begin
        data = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) data[7:0] = sb.led_byte_q;
        send_word(host_write(LEN_LED, data));
      end else if (pick < 76) begin
        send_word(any_word());
      end else if (pick < 88) begin
        // readout cut short by something else
        run_readout($urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0,
                    $urandom_range(0, 3), pick_byte(), pick_byte(), $urandom_range(0, 16));
        case ($urandom_range(0, 2))
          0:       send_word(plain(CMD_BUS_RESET));
          1:       send_word(plain(CMD_EP_READY));
          default: send_word(any_word());
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       send_word(plain(CMD_EP_READY));
          1:       send_word(plain(CMD_BUS_RESET));
          default: send_word(plain(CMD_BUS_STEP));
        endcase
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
